// ----- hdl/segi_pkg.sv -----
package segi_pkg;

  localparam int COORD_BITS_DEF = 13;
  localparam int FRAC_BITS_DEF  = 8;
  localparam int OUT_BITS       = 21;

endpackage

// ----- hdl/seg_in_if.sv -----
interface seg_in_if import segi_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] a_start_x;
  logic signed [COORD_BITS-1:0] a_start_y;
  logic signed [COORD_BITS-1:0] a_end_x;
  logic signed [COORD_BITS-1:0] a_end_y;
  logic signed [COORD_BITS-1:0] b_start_x;
  logic signed [COORD_BITS-1:0] b_start_y;
  logic signed [COORD_BITS-1:0] b_end_x;
  logic signed [COORD_BITS-1:0] b_end_y;

  modport source (
    output valid, a_start_x, a_start_y, a_end_x, a_end_y,
           b_start_x, b_start_y, b_end_x, b_end_y,
    input  ready
  );
  modport sink (
    input  valid, a_start_x, a_start_y, a_end_x, a_end_y,
           b_start_x, b_start_y, b_end_x, b_end_y,
    output ready
  );
endinterface

// ----- hdl/seg_out_if.sv -----
interface seg_out_if import segi_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic                       hit;
  logic signed [OUT_BITS-1:0] cross_x;
  logic signed [OUT_BITS-1:0] cross_y;

  modport source (output valid, hit, cross_x, cross_y, input ready);
  modport sink (input valid, hit, cross_x, cross_y, output ready);
endinterface

// ----- hdl/segi_div.sv -----
module segi_div import segi_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic [COORD_BITS+FRAC_BITS:0]    ld,
  input  logic [2*COORD_BITS+1:0]          det_i,
  input  logic [2*COORD_BITS+1:0]          rem_i,
  input  logic [COORD_BITS-1:0]            plo_i,
  output logic [COORD_BITS+FRAC_BITS-1:0]  q_o
);
  localparam int CB = COORD_BITS;
  localparam int DW = 2*CB + 2;
  localparam int QW = CB + FRAC_BITS;

  logic [DW-1:0] det_r [0:QW];
  logic [DW-1:0] rem_r [0:QW];
  logic [CB-1:0] plo_r [0:QW];
  logic [QW-1:0] q_r   [0:QW];

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      det_r[0] <= det_i;
      rem_r[0] <= rem_i;
      plo_r[0] <= plo_i;
      q_r[0]   <= '0;
    end
  end

  // one restoring quotient bit per stage, MSB first
  for (genvar j = 1; j <= QW; j++) begin : g_step
    localparam int I = QW - j;
    logic          nb;
    logic [DW-1:0] sh;
    logic          ge;

    if (I >= FRAC_BITS) begin : g_bit
      assign nb = plo_r[j-1][I-FRAC_BITS];
    end else begin : g_zero
      assign nb = 1'b0;
    end

    assign sh = {rem_r[j-1][DW-2:0], nb};
    assign ge = (sh >= det_r[j-1]);

    always_ff @(posedge clk) begin
      if (ld[j]) begin
        det_r[j] <= det_r[j-1];
        plo_r[j] <= plo_r[j-1];
        rem_r[j] <= ge ? (sh - det_r[j-1]) : sh;
        q_r[j]   <= {q_r[j-1][QW-2:0], ge};
      end
    end
  end

  assign q_o = q_r[QW];

endmodule

// ----- hdl/segment_intersection.sv -----
// Throughput: one transaction per cycle while out_if.ready is high; every stage
// has its own valid bit and holds only while it is full and the stage after it
// is full and stalled.
// The depth is set by the divider, one quotient bit per stage.
// Reset clears all valid bits; data registers are not reset.
module segment_intersection import segi_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  seg_in_if.sink     in_if,
  seg_out_if.source  out_if
);
  localparam int CB = COORD_BITS;
  localparam int DW = 2*CB + 2;
  localparam int HW = CB + 1;
  localparam int QW = CB + FRAC_BITS;
  localparam int PW = DW + CB;
  localparam int NS = QW + 7;
  localparam int SW = 2*CB + 3;
  localparam int WW = CB + FRAC_BITS + OUT_BITS + 2;

  function automatic logic in_unit(input logic signed [DW-1:0] num,
                                   input logic signed [DW-1:0] det);
    logic r;
    if (!det[DW-1]) r = !num[DW-1] && (num <= det);
    else            r = (num[DW-1] || num == '0) && (num >= det);
    return r;
  endfunction

  logic [NS:1]   v_r;
  logic [NS+1:1] ld;
  logic [NS:1]   vin;

  assign ld[NS+1] = out_if.ready;
  for (genvar k = 1; k <= NS; k++) begin : g_ld
    assign ld[k] = !v_r[k] || ld[k+1];
  end
  assign vin = {v_r[NS-1:1], in_if.valid};
  assign in_if.ready = ld[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 1; k <= NS; k++) begin
        if (ld[k]) v_r[k] <= vin[k];
      end
    end
  end

  // stage 1: differences
  logic signed [CB:0]   s1_d1x_r, s1_d1y_r, s1_d2x_r, s1_d2y_r, s1_ox_r, s1_oy_r;
  logic signed [CB-1:0] s1_p0x_r, s1_p0y_r;

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      s1_d1x_r <= (CB+1)'(in_if.a_end_x) - (CB+1)'(in_if.a_start_x);
      s1_d1y_r <= (CB+1)'(in_if.a_end_y) - (CB+1)'(in_if.a_start_y);
      s1_d2x_r <= (CB+1)'(in_if.b_end_x) - (CB+1)'(in_if.b_start_x);
      s1_d2y_r <= (CB+1)'(in_if.b_end_y) - (CB+1)'(in_if.b_start_y);
      s1_ox_r  <= (CB+1)'(in_if.a_start_x) - (CB+1)'(in_if.b_start_x);
      s1_oy_r  <= (CB+1)'(in_if.a_start_y) - (CB+1)'(in_if.b_start_y);
      s1_p0x_r <= in_if.a_start_x;
      s1_p0y_r <= in_if.a_start_y;
    end
  end

  // stage 2: products
  logic signed [DW-1:0] s2_da_r, s2_db_r, s2_sa_r, s2_sb_r, s2_ta_r, s2_tb_r;
  logic signed [CB:0]   s2_d1x_r, s2_d1y_r;
  logic signed [CB-1:0] s2_p0x_r, s2_p0y_r;

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      s2_da_r  <= s1_d1x_r * s1_d2y_r;
      s2_db_r  <= s1_d2x_r * s1_d1y_r;
      s2_sa_r  <= s1_d1x_r * s1_oy_r;
      s2_sb_r  <= s1_d1y_r * s1_ox_r;
      s2_ta_r  <= s1_d2x_r * s1_oy_r;
      s2_tb_r  <= s1_d2y_r * s1_ox_r;
      s2_d1x_r <= s1_d1x_r;
      s2_d1y_r <= s1_d1y_r;
      s2_p0x_r <= s1_p0x_r;
      s2_p0y_r <= s1_p0y_r;
    end
  end

  // stage 3: determinant and numerators
  logic signed [DW-1:0] s3_det_r, s3_snum_r, s3_tnum_r;
  logic signed [CB:0]   s3_d1x_r, s3_d1y_r;
  logic signed [CB-1:0] s3_p0x_r, s3_p0y_r;

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      s3_det_r  <= s2_da_r - s2_db_r;
      s3_snum_r <= s2_sa_r - s2_sb_r;
      s3_tnum_r <= s2_ta_r - s2_tb_r;
      s3_d1x_r  <= s2_d1x_r;
      s3_d1y_r  <= s2_d1y_r;
      s3_p0x_r  <= s2_p0x_r;
      s3_p0y_r  <= s2_p0y_r;
    end
  end

  // stage 4: hit test, magnitudes, signs
  logic signed [DW-1:0] ndet, ntnum;
  logic signed [CB:0]   nd1x, nd1y;
  logic                 hit4, negx4, negy4;
  logic [DW-1:0]        s4_detm_r, s4_tm_r;
  logic [CB-1:0]        s4_dxm_r, s4_dym_r;
  logic [SW-1:0]        s4_side_r;

  assign ndet  = -s3_det_r;
  assign ntnum = -s3_tnum_r;
  assign nd1x  = -s3_d1x_r;
  assign nd1y  = -s3_d1y_r;
  assign hit4  = (s3_det_r != '0) && in_unit(s3_snum_r, s3_det_r)
                 && in_unit(s3_tnum_r, s3_det_r);
  assign negx4 = s3_tnum_r[DW-1] ^ s3_d1x_r[CB] ^ s3_det_r[DW-1];
  assign negy4 = s3_tnum_r[DW-1] ^ s3_d1y_r[CB] ^ s3_det_r[DW-1];

  always_ff @(posedge clk) begin
    if (ld[4]) begin
      s4_detm_r <= s3_det_r[DW-1] ? ndet : s3_det_r;
      s4_tm_r   <= s3_tnum_r[DW-1] ? ntnum : s3_tnum_r;
      s4_dxm_r  <= s3_d1x_r[CB] ? nd1x[CB-1:0] : s3_d1x_r[CB-1:0];
      s4_dym_r  <= s3_d1y_r[CB] ? nd1y[CB-1:0] : s3_d1y_r[CB-1:0];
      s4_side_r <= {hit4, negx4, negy4, s3_p0x_r, s3_p0y_r};
    end
  end

  // stage 5: partial products of |tnum| * |dir|
  logic [HW+CB-1:0] s5_plx_r, s5_phx_r, s5_ply_r, s5_phy_r;
  logic [DW-1:0]    s5_detm_r;
  logic [SW-1:0]    s5_side_r;

  always_ff @(posedge clk) begin
    if (ld[5]) begin
      s5_plx_r  <= s4_tm_r[HW-1:0]  * s4_dxm_r;
      s5_phx_r  <= s4_tm_r[DW-1:HW] * s4_dxm_r;
      s5_ply_r  <= s4_tm_r[HW-1:0]  * s4_dym_r;
      s5_phy_r  <= s4_tm_r[DW-1:HW] * s4_dym_r;
      s5_detm_r <= s4_detm_r;
      s5_side_r <= s4_side_r;
    end
  end

  // stage 6 onward: product sum feeds the dividers
  logic [PW-1:0] px, py;
  logic [QW-1:0] qx, qy;

  assign px = (PW'(s5_phx_r) << HW) + PW'(s5_plx_r);
  assign py = (PW'(s5_phy_r) << HW) + PW'(s5_ply_r);

  segi_div #(.COORD_BITS(CB), .FRAC_BITS(FRAC_BITS)) u_div_x (
    .clk   (clk),
    .ld    (ld[QW+6:6]),
    .det_i (s5_detm_r),
    .rem_i (px[PW-1:CB]),
    .plo_i (px[CB-1:0]),
    .q_o   (qx)
  );

  segi_div #(.COORD_BITS(CB), .FRAC_BITS(FRAC_BITS)) u_div_y (
    .clk   (clk),
    .ld    (ld[QW+6:6]),
    .det_i (s5_detm_r),
    .rem_i (py[PW-1:CB]),
    .plo_i (py[CB-1:0]),
    .q_o   (qy)
  );

  logic [SW-1:0] dl_r [0:QW];

  always_ff @(posedge clk) begin
    if (ld[6]) dl_r[0] <= s5_side_r;
    for (int j = 1; j <= QW; j++) begin
      if (ld[6+j]) dl_r[j] <= dl_r[j-1];
    end
  end

  // output stage
  logic                 o_hit, o_negx, o_negy;
  logic signed [CB-1:0] o_p0x, o_p0y;
  logic signed [WW-1:0] bx, by, rx, ry;
  logic                       hit_r;
  logic signed [OUT_BITS-1:0] cross_x_r, cross_y_r;

  assign {o_hit, o_negx, o_negy, o_p0x, o_p0y} = dl_r[QW];
  assign bx = WW'(o_p0x) <<< FRAC_BITS;
  assign by = WW'(o_p0y) <<< FRAC_BITS;
  assign rx = o_negx ? (bx - WW'(qx)) : (bx + WW'(qx));
  assign ry = o_negy ? (by - WW'(qy)) : (by + WW'(qy));

  always_ff @(posedge clk) begin
    if (ld[NS]) begin
      hit_r     <= o_hit;
      cross_x_r <= o_hit ? rx[OUT_BITS-1:0] : '0;
      cross_y_r <= o_hit ? ry[OUT_BITS-1:0] : '0;
    end
  end

  assign out_if.valid   = v_r[NS];
  assign out_if.hit     = hit_r;
  assign out_if.cross_x = cross_x_r;
  assign out_if.cross_y = cross_y_r;

endmodule
